### sv/teq_pkg.sv
`default_nettype none

package teq_pkg;

  localparam int NUM_TIMERS_DEF = 16;

  localparam int TIME_W = 63;
  localparam int IV_W   = 32;
  localparam int GEN_W  = 16;
  localparam int SLOT_W = 4;

  typedef logic [1:0] req_code_t;
  localparam req_code_t REQ_ADD    = 2'd0;
  localparam req_code_t REQ_CANCEL = 2'd1;
  localparam req_code_t REQ_TICK   = 2'd2;

  typedef logic [1:0] kind_code_t;
  localparam kind_code_t KIND_ADD_ACK    = 2'd0;
  localparam kind_code_t KIND_CANCEL_ACK = 2'd1;
  localparam kind_code_t KIND_EXPIRED    = 2'd2;
  localparam kind_code_t KIND_TICK_SUM   = 2'd3;

  typedef logic [1:0] status_code_t;
  localparam status_code_t STAT_OK        = 2'd0;
  localparam status_code_t STAT_FULL      = 2'd1;
  localparam status_code_t STAT_NOT_FOUND = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CAN_CHK,
    ST_DUE_SCAN,
    ST_SEL_SCAN,
    ST_SEL_EMIT,
    ST_REARM,
    ST_MIN_SCAN,
    ST_ADD_DONE,
    ST_FINISH
  } teq_state_t;

  typedef struct packed {
    req_code_t          req_type;
    logic [TIME_W-1:0]  deadline;
    logic [IV_W-1:0]    repeat_us;
    logic [SLOT_W-1:0]  slot;
    logic [GEN_W-1:0]   generation;
    logic [TIME_W-1:0]  now_us;
  } teq_in_t;

  typedef struct packed {
    kind_code_t         kind;
    status_code_t       status;
    logic [SLOT_W-1:0]  out_slot;
    logic [GEN_W-1:0]   out_generation;
    logic               earliest_changed;
    logic [TIME_W-1:0]  next_deadline;
    logic               deadline_valid;
    logic               last;
  } teq_out_t;

endpackage

`default_nettype wire

### sv/timer_expiry_queue.sv
// An add yields its single result beat after the minimum pass; a cancel first checks the slot,
// then runs the minimum pass. A tick ends in a summary beat; every pass walks all slots
// through one 63-bit comparator, one slot per cycle, reading the memories.
// One request at a time: busy drops in the cycle that carries the last result beat; results
// appear for one cycle each on out_valid and the receiver cannot stall them.
// Reset (rst_n low, synchronous) frees all slots and zeroes the generation counter.
`default_nettype none

module timer_expiry_queue
  import teq_pkg::*;
#(
  parameter int NUM_TIMERS = NUM_TIMERS_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  output logic          busy,
  input  wire teq_in_t  in_data,
  output logic          out_valid,
  output teq_out_t      out_data
);

  // Slot index width and scan counter width (the counter also holds NUM_TIMERS).
  localparam int SW = $clog2(NUM_TIMERS);
  localparam int CW = $clog2(NUM_TIMERS + 1);

  teq_state_t state_r, state_nxt;

  // Latched request and scan sequencer.
  teq_in_t            req_r, req_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic [SW-1:0]      pidx_r, pidx_nxt;
  logic               pvalid_r, pvalid_nxt;

  // Running minimum / pick of the current pass.
  logic               any_r, any_nxt;
  logic [TIME_W-1:0]  best_r, best_nxt;
  logic [SW-1:0]      best_slot_r, best_slot_nxt;
  logic [GEN_W-1:0]   best_gen_r, best_gen_nxt;
  logic               free_found_r, free_found_nxt;
  logic [SW-1:0]      free_slot_r, free_slot_nxt;
  status_code_t       status_r, status_nxt;

  // Per-slot flags.
  logic [NUM_TIMERS-1:0] valid_r, valid_nxt;
  logic [NUM_TIMERS-1:0] due_r, due_nxt;
  logic [NUM_TIMERS-1:0] done_r, done_nxt;

  logic [GEN_W-1:0]   gen_ctr_r, gen_ctr_nxt;
  logic [GEN_W-1:0]   gen_new;

  teq_out_t           out_r, out_nxt;
  logic               out_valid_r, out_valid_nxt;

  // Slot memories with registered read data.
  logic [TIME_W-1:0]  dl_mem  [NUM_TIMERS];
  logic [IV_W-1:0]    iv_mem  [NUM_TIMERS];
  logic [GEN_W-1:0]   gen_mem [NUM_TIMERS];
  logic [TIME_W-1:0]  d_dl_r;
  logic [IV_W-1:0]    d_iv_r;
  logic [GEN_W-1:0]   d_gen_r;

  logic               rd_en;
  logic [SW-1:0]      rd_addr;
  logic               dl_we;
  logic [SW-1:0]      dl_waddr;
  logic [TIME_W-1:0]  dl_wdata;
  logic               add_we;

  logic               accept;
  logic               scan_st;
  logic               cnt_end;
  logic               in_slot_ok;
  logic               req_slot_ok;
  logic [SW-1:0]      can_idx;
  logic               cancel_hit;
  logic               changed;

  // Shared comparator: cmp_a < cmp_b.
  logic [TIME_W-1:0]  cmp_a, cmp_b;
  logic               lt;

  // Re-arm adder with saturation at the top of the time range.
  logic [TIME_W:0]    rearm_sum;
  logic [TIME_W-1:0]  rearm_dl;

  assign accept  = start && !busy;
  assign busy    = (state_r != ST_IDLE);
  assign scan_st = (state_r == ST_DUE_SCAN) || (state_r == ST_SEL_SCAN) ||
                   (state_r == ST_REARM) || (state_r == ST_MIN_SCAN);
  // A pass issues reads while the counter runs 0..N-1 and processes the data in the following
  // cycle, so the last slot is handled in the cycle where the counter reads N.
  assign cnt_end = scan_st && (cnt_r == CW'(NUM_TIMERS));

  assign in_slot_ok  = (32'(in_data.slot) < 32'(NUM_TIMERS));
  assign req_slot_ok = (32'(req_r.slot) < 32'(NUM_TIMERS));
  assign can_idx     = SW'(req_r.slot);
  assign gen_new     = gen_ctr_r + GEN_W'(1);

  assign rearm_sum = (TIME_W+1)'(req_r.now_us) + (TIME_W+1)'(d_iv_r);
  assign rearm_dl  = rearm_sum[TIME_W] ? {TIME_W{1'b1}} : rearm_sum[TIME_W-1:0];

  assign cancel_hit = req_slot_ok && valid_r[can_idx] && (d_gen_r == req_r.generation);
  assign changed    = !any_r || lt;

  // Read port: scans walk the slots in order; a cancel reads its slot once.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = cnt_r[SW-1:0];
    if (scan_st) begin
      rd_en = (cnt_r < CW'(NUM_TIMERS));
    end else if (state_r == ST_IDLE) begin
      rd_addr = SW'(in_data.slot);
      rd_en   = accept && (in_data.req_type == REQ_CANCEL) && in_slot_ok;
    end
  end

  // Route the operands of the one comparator by state.
  always_comb begin
    unique case (state_r)
      ST_DUE_SCAN: begin
        // now < deadline means the slot is not due yet
        cmp_a = req_r.now_us;
        cmp_b = d_dl_r;
      end
      ST_ADD_DONE: begin
        cmp_a = req_r.deadline;
        cmp_b = best_r;
      end
      default: begin
        cmp_a = d_dl_r;
        cmp_b = best_r;
      end
    endcase
  end
  assign lt = (cmp_a < cmp_b);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          priority case (in_data.req_type)
            REQ_ADD:    state_nxt = ST_MIN_SCAN;
            REQ_CANCEL: state_nxt = ST_CAN_CHK;
            REQ_TICK:   state_nxt = ST_DUE_SCAN;
            default:    state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_CAN_CHK:  state_nxt = ST_MIN_SCAN;
      ST_DUE_SCAN: if (cnt_end) state_nxt = ST_SEL_SCAN;
      ST_SEL_SCAN: if (cnt_end) state_nxt = ST_SEL_EMIT;
      // keep picking until a pass finds nothing left to emit
      ST_SEL_EMIT: state_nxt = any_r ? ST_SEL_SCAN : ST_REARM;
      ST_REARM:    if (cnt_end) state_nxt = ST_MIN_SCAN;
      ST_MIN_SCAN: begin
        if (cnt_end) begin
          state_nxt = (req_r.req_type == REQ_ADD) ? ST_ADD_DONE : ST_FINISH;
        end
      end
      ST_ADD_DONE: state_nxt = ST_IDLE;
      ST_FINISH:   state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // Datapath, flag updates and result beats.
  always_comb begin
    req_nxt        = req_r;
    cnt_nxt        = '0;
    pidx_nxt       = rd_addr;
    pvalid_nxt     = 1'b0;
    any_nxt        = any_r;
    best_nxt       = best_r;
    best_slot_nxt  = best_slot_r;
    best_gen_nxt   = best_gen_r;
    free_found_nxt = free_found_r;
    free_slot_nxt  = free_slot_r;
    status_nxt     = status_r;
    valid_nxt      = valid_r;
    due_nxt        = due_r;
    done_nxt       = done_r;
    gen_ctr_nxt    = gen_ctr_r;
    out_nxt        = out_r;
    out_valid_nxt  = 1'b0;
    dl_we          = 1'b0;
    dl_waddr       = pidx_r;
    dl_wdata       = rearm_dl;
    add_we         = 1'b0;

    // Advance the pass counter; restart the running minimum at pass start.
    if (scan_st) begin
      cnt_nxt    = cnt_end ? '0 : cnt_r + CW'(1);
      pvalid_nxt = rd_en;
      if (cnt_r == '0) begin
        any_nxt        = 1'b0;
        free_found_nxt = 1'b0;
      end
    end

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          req_nxt    = in_data;
          status_nxt = STAT_OK;
          done_nxt   = '0;
        end
      end

      ST_CAN_CHK: begin
        if (cancel_hit) begin
          valid_nxt[can_idx] = 1'b0;
        end
        status_nxt = cancel_hit ? STAT_OK : STAT_NOT_FOUND;
      end

      ST_DUE_SCAN: begin
        if (pvalid_r) begin
          due_nxt[pidx_r] = valid_r[pidx_r] && !lt;
        end
      end

      ST_SEL_SCAN: begin
        // strict compare keeps the lowest slot on equal deadlines
        if (pvalid_r && due_r[pidx_r] && !done_r[pidx_r] && (!any_r || lt)) begin
          any_nxt       = 1'b1;
          best_nxt      = d_dl_r;
          best_slot_nxt = pidx_r;
          best_gen_nxt  = d_gen_r;
        end
      end

      ST_SEL_EMIT: begin
        if (any_r) begin
          done_nxt[best_slot_r]  = 1'b1;
          out_nxt                = '0;
          out_nxt.kind           = KIND_EXPIRED;
          out_nxt.status         = STAT_OK;
          out_nxt.out_slot       = SLOT_W'(best_slot_r);
          out_nxt.out_generation = best_gen_r;
          out_valid_nxt          = 1'b1;
        end
      end

      ST_REARM: begin
        if (pvalid_r && due_r[pidx_r]) begin
          if (d_iv_r != '0) begin
            dl_we = 1'b1;
          end else begin
            valid_nxt[pidx_r] = 1'b0;
          end
        end
      end

      ST_MIN_SCAN: begin
        if (pvalid_r) begin
          if (valid_r[pidx_r] && (!any_r || lt)) begin
            any_nxt  = 1'b1;
            best_nxt = d_dl_r;
          end
          if (!valid_r[pidx_r] && !free_found_r) begin
            free_found_nxt = 1'b1;
            free_slot_nxt  = pidx_r;
          end
        end
      end

      ST_ADD_DONE: begin
        out_nxt       = '0;
        out_nxt.kind  = KIND_ADD_ACK;
        out_nxt.last  = 1'b1;
        out_valid_nxt = 1'b1;
        if (!free_found_r) begin
          out_nxt.status         = STAT_FULL;
          out_nxt.next_deadline  = any_r ? best_r : '0;
          out_nxt.deadline_valid = any_r;
        end else begin
          gen_ctr_nxt                = gen_new;
          valid_nxt[free_slot_r]     = 1'b1;
          add_we                     = 1'b1;
          dl_we                      = 1'b1;
          dl_waddr                   = free_slot_r;
          dl_wdata                   = req_r.deadline;
          out_nxt.status             = STAT_OK;
          out_nxt.out_slot           = SLOT_W'(free_slot_r);
          out_nxt.out_generation     = gen_new;
          out_nxt.earliest_changed   = changed;
          out_nxt.next_deadline      = changed ? req_r.deadline : best_r;
          out_nxt.deadline_valid     = 1'b1;
        end
      end

      ST_FINISH: begin
        out_nxt                = '0;
        out_nxt.kind           = (req_r.req_type == REQ_CANCEL) ? KIND_CANCEL_ACK
                                                                 : KIND_TICK_SUM;
        out_nxt.status         = status_r;
        out_nxt.next_deadline  = any_r ? best_r : '0;
        out_nxt.deadline_valid = any_r;
        out_nxt.last           = 1'b1;
        out_valid_nxt          = 1'b1;
      end

      default: begin
      end
    endcase
  end

  // Slot memories: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (dl_we) begin
      dl_mem[dl_waddr] <= dl_wdata;
    end
    if (add_we) begin
      iv_mem[free_slot_r]  <= req_r.repeat_us;
      gen_mem[free_slot_r] <= gen_new;
    end
    if (rd_en) begin
      d_dl_r  <= dl_mem[rd_addr];
      d_iv_r  <= iv_mem[rd_addr];
      d_gen_r <= gen_mem[rd_addr];
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      pvalid_r    <= 1'b0;
      valid_r     <= '0;
      gen_ctr_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pvalid_r    <= pvalid_nxt;
      valid_r     <= valid_nxt;
      gen_ctr_r   <= gen_ctr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload and per-pass scratch.
  always_ff @(posedge clk) begin
    req_r        <= req_nxt;
    pidx_r       <= pidx_nxt;
    any_r        <= any_nxt;
    best_r       <= best_nxt;
    best_slot_r  <= best_slot_nxt;
    best_gen_r   <= best_gen_nxt;
    free_found_r <= free_found_nxt;
    free_slot_r  <= free_slot_nxt;
    status_r     <= status_nxt;
    due_r        <= due_nxt;
    done_r       <= done_nxt;
    out_r        <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

### bench/tb_timer_expiry_queue.sv
`default_nettype none

module tb_timer_expiry_queue;
  import teq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NT = NUM_TIMERS_DEF;
  localparam logic [TIME_W-1:0] T_MAX = {TIME_W{1'b1}};

  // The block ignores this request code, so the package has no name for it.
  localparam req_code_t REQ_UNUSED = 2'd3;

  localparam int ITEM_TARGET   = 380;
  // Worst tick: every slot expires, so the tick runs (NT+4) passes.
  localparam int TICK_WORST    = (NT + 4) * (NT + 2);
  localparam int SETTLE_CYCLES = 2 * TICK_WORST;
  localparam int CYCLE_LIMIT   = 1000000;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     start = 1'b0;
  teq_in_t  in_data = '0;
  logic     busy;
  logic     out_valid;
  teq_out_t out_data;

  // Requests waiting for the driver, and the replies the table still owes us.
  teq_in_t  pending_requests[$];
  teq_out_t owed_replies[$];

  // Shadow copy of the timer table, updated as each request beat is accepted.
  logic              tm_live [NT] = '{default: 1'b0};
  logic [TIME_W-1:0] tm_due_at [NT];
  logic [IV_W-1:0]   tm_period [NT];
  logic [GEN_W-1:0]  tm_gen [NT];
  logic [GEN_W-1:0]  gen_ctr = '0;

  int          items_sent = 0;
  int          fail_count = 0;
  int unsigned cycle_count = 0;

  // Driver pacing: gap before the next request, an optional wait for idle,
  // and stretches of back-to-back requests.
  int unsigned gap_left = 0;
  int unsigned calm_left = 0;
  logic        gap_after_idle = 1'b0;

  timer_expiry_queue #(.NUM_TIMERS(NT)) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  always #6 clk = ~clk;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // ---------------------------------------------------------------------------
  // Timer table prediction
  // ---------------------------------------------------------------------------

  // Saturate base + delta at the largest representable time.
  function automatic logic [TIME_W-1:0] capped_sum(logic [TIME_W-1:0] base,
                                                   logic [IV_W-1:0] delta);
    logic [TIME_W:0] sum;
    sum = {1'b0, base} + delta;
    return (sum > {1'b0, T_MAX}) ? T_MAX : sum[TIME_W-1:0];
  endfunction

  // Earliest pending deadline; returns whether any timer is pending.
  function automatic logic soonest(output logic [TIME_W-1:0] soon_at);
    logic any;
    any = 1'b0;
    soon_at = '0;
    for (int i = 0; i < NT; i++) begin
      if (tm_live[i] && (!any || tm_due_at[i] < soon_at)) begin
        soon_at = tm_due_at[i];
        any = 1'b1;
      end
    end
    return any;
  endfunction

  // Apply one accepted request to the shadow table and queue its replies.
  function automatic void apply_to_timer_table(teq_in_t rq);
    teq_out_t          r;
    logic [TIME_W-1:0] nxt;
    logic              was_any;
    int                free_idx;
    int                pick;
    logic              due [NT];
    logic              unsent [NT];
    r = '0;
    case (rq.req_type)
      REQ_ADD: begin
        free_idx = -1;
        for (int i = NT - 1; i >= 0; i--) begin
          if (!tm_live[i]) free_idx = i;
        end
        r.kind = KIND_ADD_ACK;
        if (free_idx < 0) begin
          r.status = STAT_FULL;
        end else begin
          was_any = soonest(nxt);
          r.earliest_changed = !was_any || rq.deadline < nxt;
          gen_ctr = gen_ctr + 1'b1;
          tm_live[free_idx]   = 1'b1;
          tm_due_at[free_idx] = rq.deadline;
          tm_period[free_idx] = rq.repeat_us;
          tm_gen[free_idx]    = gen_ctr;
          r.status         = STAT_OK;
          r.out_slot       = free_idx[SLOT_W-1:0];
          r.out_generation = gen_ctr;
        end
        r.deadline_valid = soonest(nxt);
        r.next_deadline  = nxt;
        r.last           = 1'b1;
        owed_replies.push_back(r);
      end
      REQ_CANCEL: begin
        r.kind   = KIND_CANCEL_ACK;
        r.status = STAT_NOT_FOUND;
        if (int'(rq.slot) < NT && tm_live[rq.slot] && tm_gen[rq.slot] == rq.generation) begin
          tm_live[rq.slot] = 1'b0;
          r.status = STAT_OK;
        end
        r.deadline_valid = soonest(nxt);
        r.next_deadline  = nxt;
        r.last           = 1'b1;
        owed_replies.push_back(r);
      end
      REQ_TICK: begin
        for (int i = 0; i < NT; i++) begin
          due[i]    = tm_live[i] && tm_due_at[i] <= rq.now_us;
          unsent[i] = due[i];
        end
        // Emit due timers earliest first; strict compare keeps the lower slot on ties.
        for (int n = 0; n < NT; n++) begin
          pick = -1;
          for (int i = 0; i < NT; i++) begin
            if (unsent[i] && (pick < 0 || tm_due_at[i] < tm_due_at[pick])) pick = i;
          end
          if (pick < 0) break;
          unsent[pick] = 1'b0;
          r = '0;
          r.kind           = KIND_EXPIRED;
          r.status         = STAT_OK;
          r.out_slot       = pick[SLOT_W-1:0];
          r.out_generation = tm_gen[pick];
          owed_replies.push_back(r);
        end
        // Re-arm periodic timers from now, drop one-shots.
        for (int i = 0; i < NT; i++) begin
          if (due[i]) begin
            if (tm_period[i] != '0) tm_due_at[i] = capped_sum(rq.now_us, tm_period[i]);
            else tm_live[i] = 1'b0;
          end
        end
        r = '0;
        r.kind           = KIND_TICK_SUM;
        r.status         = STAT_OK;
        r.deadline_valid = soonest(nxt);
        r.next_deadline  = nxt;
        r.last           = 1'b1;
        owed_replies.push_back(r);
      end
      default: ;  // unknown code: no reply, no state change
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: present one request per beat, pause a random number of cycles
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : driver
    logic hold_high;
    if (!rst_n) begin
      start <= 1'b0;
      gap_left = 0;
    end else begin
      hold_high = start;
      if (start && !busy) begin
        // Beat accepted: predict its replies now, then pick the next pause.
        apply_to_timer_table(in_data);
        hold_high = 1'b0;
        if (calm_left > 0) begin
          calm_left--;
          gap_left = 0;
        end else begin
          gap_left = $urandom_range(0, 7);
          if ($urandom_range(0, 15) == 0) calm_left = $urandom_range(10, 30);
        end
        gap_after_idle = $urandom_range(0, 1);
      end
      if (!hold_high && pending_requests.size() != 0) begin
        if (gap_left == 0) begin
          in_data <= pending_requests.pop_front();
          hold_high = 1'b1;
        end else if (!(gap_after_idle && busy)) begin
          // Either burn the pause right away or only once the block is idle.
          gap_left--;
        end
      end
      start <= hold_high;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: every result beat must match the oldest owed reply
  // ---------------------------------------------------------------------------
  function automatic void check_field(string field, logic [TIME_W-1:0] want,
                                      logic [TIME_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", field, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin : monitor
    teq_out_t want;
    if (rst_n && out_valid) begin
      if (owed_replies.size() == 0) begin
        $error("result beat with no reply owed: %p", out_data);
        fail_count++;
      end else begin
        want = owed_replies.pop_front();
        check_field("kind", TIME_W'(want.kind), TIME_W'(out_data.kind));
        check_field("status", TIME_W'(want.status), TIME_W'(out_data.status));
        check_field("out_slot", TIME_W'(want.out_slot), TIME_W'(out_data.out_slot));
        check_field("out_generation", TIME_W'(want.out_generation),
                    TIME_W'(out_data.out_generation));
        check_field("earliest_changed", TIME_W'(want.earliest_changed),
                    TIME_W'(out_data.earliest_changed));
        check_field("next_deadline", want.next_deadline, out_data.next_deadline);
        check_field("deadline_valid", TIME_W'(want.deadline_valid),
                    TIME_W'(out_data.deadline_valid));
        check_field("last", TIME_W'(want.last), TIME_W'(out_data.last));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Request builders
  // ---------------------------------------------------------------------------
  function automatic logic [TIME_W-1:0] any_time();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[TIME_W-1:0];
  endfunction

  // Start from noise in every field but the request code so unused fields toggle too.
  function automatic teq_in_t scrambled(req_code_t code);
    teq_in_t r;
    r.req_type   = code;
    r.deadline   = any_time();
    r.repeat_us  = $urandom;
    r.slot       = SLOT_W'($urandom);
    r.generation = GEN_W'($urandom);
    r.now_us     = any_time();
    return r;
  endfunction

  task automatic post(teq_in_t r);
    pending_requests.push_back(r);
    if (r.req_type != REQ_UNUSED) items_sent++;
  endtask

  task automatic post_add(logic [TIME_W-1:0] dl, logic [IV_W-1:0] iv);
    teq_in_t r;
    r = scrambled(REQ_ADD);
    r.deadline  = dl;
    r.repeat_us = iv;
    post(r);
  endtask

  task automatic post_cancel(logic [SLOT_W-1:0] s, logic [GEN_W-1:0] g);
    teq_in_t r;
    r = scrambled(REQ_CANCEL);
    r.slot       = s;
    r.generation = g;
    post(r);
  endtask

  task automatic post_tick(logic [TIME_W-1:0] now);
    teq_in_t r;
    r = scrambled(REQ_TICK);
    r.now_us = now;
    post(r);
  endtask

  // Hold until every queued request has been taken by the block.
  task automatic wait_taken();
    while (pending_requests.size() != 0 || start) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Watchdog
  // ---------------------------------------------------------------------------
  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("simulation failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    logic [TIME_W-1:0] sim_now;
    logic [TIME_W-1:0] dl;
    logic [IV_W-1:0]   iv;
    int                live_slots[$];
    int                roll;
    int                batch;
    int                s;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: empty table, then adds at the time extremes. Generations
    // start at 1 after reset, so the slot/generation pairs are known.
    post_tick('0);                           // empty tick: no pending deadline
    post_cancel('0, '0);                     // cancel on an empty table
    post_add(T_MAX, '0);                     // slot 0 gen 1, new earliest
    post_add('0, {IV_W{1'b1}});              // slot 1 gen 2, new earliest
    post_add('0, '0);                        // slot 2 gen 3, tie: not earlier
    post_tick('0);                           // expire slots 1,2 by slot on tie
    post_cancel(SLOT_W'(1), ~GEN_W'(2));     // wrong generation
    post_cancel(SLOT_W'(2), GEN_W'(3));      // slot already freed
    post_add(T_MAX - TIME_W'(5), {IV_W{1'b1}});  // slot 2 gen 4
    post_tick(T_MAX - TIME_W'(1));           // both periodic re-arms saturate
    post_tick(T_MAX);                        // three-way tie at the maximum
    // Fill the rest of the table, then overflow it.
    for (int i = 0; i < NT - 2; i++) begin
      post_add(TIME_W'($urandom_range(0, 2000)),
               ($urandom_range(0, 3) == 0) ? IV_W'(0) : IV_W'($urandom_range(1, 500)));
    end
    post_add(any_time(), $urandom);          // table full
    post_cancel(SLOT_W'(1), GEN_W'(2));      // matching cancel
    wait_taken();

    // Random: mostly live traffic around a moving time base, with cancels
    // aimed at real timers, occasional time jumps and some junk requests.
    sim_now = '0;
    while (items_sent < ITEM_TARGET) begin
      batch = $urandom_range(1, 6);
      for (int b = 0; b < batch; b++) begin
        roll = $urandom_range(0, 99);
        if (roll < 40) begin
          case ($urandom_range(0, 9))
            0:       dl = any_time();
            1:       dl = T_MAX;
            2:       dl = sim_now;
            default: dl = capped_sum(sim_now, IV_W'($urandom_range(0, 800)));
          endcase
          case ($urandom_range(0, 9))
            0, 1, 2, 3: iv = '0;
            4, 5, 6:    iv = IV_W'($urandom_range(1, 300));
            7:          iv = $urandom;
            8:          iv = {IV_W{1'b1}};
            default:    iv = IV_W'(1);
          endcase
          post_add(dl, iv);
        end else if (roll < 70) begin
          roll = $urandom_range(0, 99);
          if (roll < 5) sim_now = TIME_W'($urandom_range(0, 2000));
          else if (roll < 8) sim_now = any_time();
          else if (roll < 11) sim_now = T_MAX - TIME_W'($urandom_range(0, 500));
          else if (roll < 20) sim_now = sim_now;  // repeat the same time
          else sim_now = capped_sum(sim_now, IV_W'($urandom_range(1, 400)));
          post_tick(sim_now);
        end else if (roll < 95) begin
          live_slots.delete();
          for (int i = 0; i < NT; i++) if (tm_live[i]) live_slots.push_back(i);
          roll = $urandom_range(0, 99);
          if (live_slots.size() != 0 && roll < 75) begin
            s = live_slots[$urandom_range(0, live_slots.size() - 1)];
            if (roll < 55) post_cancel(SLOT_W'(s), tm_gen[s]);
            else post_cancel(SLOT_W'(s), tm_gen[s] ^ GEN_W'($urandom_range(1, 65535)));
          end else begin
            post_cancel(SLOT_W'($urandom), GEN_W'($urandom));
          end
        end else begin
          post(scrambled(REQ_UNUSED));
        end
      end
      // Drain the batch so cancels see the table as it really stands.
      wait_taken();
    end

    // Wind down: all replies in, then let the block settle.
    while (owed_replies.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
